[src/mck_pkg.sv]
// Shared types and constant tables for the Morse character keyer.
`default_nettype none

package mck_pkg;

  // Symbol codes held in each pattern slot
  typedef enum logic [1:0] {
    SYM_NONE = 2'd0,
    SYM_DOT  = 2'd1,
    SYM_DASH = 2'd2
  } sym_e;

  // Segment length classes, in units
  typedef enum logic [1:0] {
    DUR_1U = 2'd0,
    DUR_2U = 2'd1,
    DUR_3U = 2'd2,
    DUR_8U = 2'd3
  } dur_e;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned SPEED_W    = 4;
  localparam int unsigned DUR_W      = 23;
  localparam int unsigned ROM_ROWS   = 36;
  localparam int unsigned ROM_SLOTS  = 5;
  localparam int unsigned ROW_W      = $clog2(ROM_ROWS);
  localparam int unsigned SPEED_CNT  = 2 ** SPEED_W;
  localparam int unsigned DUR_KINDS  = 4;

  localparam logic [CHAR_W-1:0] CHAR_UPPER_A     = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z     = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z     = 8'h7A;
  localparam logic [CHAR_W-1:0] CHAR_DIGIT_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_DIGIT_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_SPACE       = 8'h20;
  // digits land after the 26 letter rows
  localparam logic [CHAR_W-1:0] DIGIT_ROW_OFFSET = 8'h16;

  localparam logic [SPEED_W-1:0] SPEED_RESET = 4'd1;

  localparam int unsigned US_1U = 1000000;
  localparam int unsigned US_2U = 2000000;
  localparam int unsigned US_3U = 3000000;
  localparam int unsigned US_8U = 8000000;

  // Duration per class and speed; speed zero reads as speed one
  localparam logic [DUR_W-1:0] DUR_TABLE [DUR_KINDS][SPEED_CNT] = '{
    '{23'(US_1U / 1),  23'(US_1U / 1),  23'(US_1U / 2),  23'(US_1U / 3),
      23'(US_1U / 4),  23'(US_1U / 5),  23'(US_1U / 6),  23'(US_1U / 7),
      23'(US_1U / 8),  23'(US_1U / 9),  23'(US_1U / 10), 23'(US_1U / 11),
      23'(US_1U / 12), 23'(US_1U / 13), 23'(US_1U / 14), 23'(US_1U / 15)},
    '{23'(US_2U / 1),  23'(US_2U / 1),  23'(US_2U / 2),  23'(US_2U / 3),
      23'(US_2U / 4),  23'(US_2U / 5),  23'(US_2U / 6),  23'(US_2U / 7),
      23'(US_2U / 8),  23'(US_2U / 9),  23'(US_2U / 10), 23'(US_2U / 11),
      23'(US_2U / 12), 23'(US_2U / 13), 23'(US_2U / 14), 23'(US_2U / 15)},
    '{23'(US_3U / 1),  23'(US_3U / 1),  23'(US_3U / 2),  23'(US_3U / 3),
      23'(US_3U / 4),  23'(US_3U / 5),  23'(US_3U / 6),  23'(US_3U / 7),
      23'(US_3U / 8),  23'(US_3U / 9),  23'(US_3U / 10), 23'(US_3U / 11),
      23'(US_3U / 12), 23'(US_3U / 13), 23'(US_3U / 14), 23'(US_3U / 15)},
    '{23'(US_8U / 1),  23'(US_8U / 1),  23'(US_8U / 2),  23'(US_8U / 3),
      23'(US_8U / 4),  23'(US_8U / 5),  23'(US_8U / 6),  23'(US_8U / 7),
      23'(US_8U / 8),  23'(US_8U / 9),  23'(US_8U / 10), 23'(US_8U / 11),
      23'(US_8U / 12), 23'(US_8U / 13), 23'(US_8U / 14), 23'(US_8U / 15)}
  };

  // Rows a..z then 0..9, first symbol in slot 0
  localparam sym_e PATTERN_ROM [ROM_ROWS][ROM_SLOTS] = '{
    '{SYM_DOT,  SYM_DASH, SYM_NONE, SYM_NONE, SYM_NONE}, // a
    '{SYM_DASH, SYM_DOT,  SYM_DOT,  SYM_DOT,  SYM_NONE}, // b
    '{SYM_DASH, SYM_DOT,  SYM_DASH, SYM_DOT,  SYM_NONE}, // c
    '{SYM_DASH, SYM_DOT,  SYM_DOT,  SYM_NONE, SYM_NONE}, // d
    '{SYM_DOT,  SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE}, // e
    '{SYM_DOT,  SYM_DOT,  SYM_DASH, SYM_DOT,  SYM_NONE}, // f
    '{SYM_DASH, SYM_DASH, SYM_DOT,  SYM_NONE, SYM_NONE}, // g
    '{SYM_DOT,  SYM_DOT,  SYM_DOT,  SYM_DOT,  SYM_NONE}, // h
    '{SYM_DOT,  SYM_DOT,  SYM_NONE, SYM_NONE, SYM_NONE}, // i
    '{SYM_DOT,  SYM_DASH, SYM_DASH, SYM_DASH, SYM_NONE}, // j
    '{SYM_DASH, SYM_DOT,  SYM_DASH, SYM_NONE, SYM_NONE}, // k
    '{SYM_DOT,  SYM_DASH, SYM_DOT,  SYM_DOT,  SYM_NONE}, // l
    '{SYM_DASH, SYM_DASH, SYM_NONE, SYM_NONE, SYM_NONE}, // m
    '{SYM_DASH, SYM_DOT,  SYM_NONE, SYM_NONE, SYM_NONE}, // n
    '{SYM_DASH, SYM_DASH, SYM_DASH, SYM_NONE, SYM_NONE}, // o
    '{SYM_DOT,  SYM_DASH, SYM_DASH, SYM_DOT,  SYM_NONE}, // p
    '{SYM_DASH, SYM_DASH, SYM_DOT,  SYM_DASH, SYM_NONE}, // q
    '{SYM_DOT,  SYM_DASH, SYM_DOT,  SYM_NONE, SYM_NONE}, // r
    '{SYM_DOT,  SYM_DOT,  SYM_DOT,  SYM_NONE, SYM_NONE}, // s
    '{SYM_DASH, SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE}, // t
    '{SYM_DOT,  SYM_DOT,  SYM_DASH, SYM_NONE, SYM_NONE}, // u
    '{SYM_DOT,  SYM_DOT,  SYM_DOT,  SYM_DASH, SYM_NONE}, // v
    '{SYM_DOT,  SYM_DASH, SYM_DASH, SYM_NONE, SYM_NONE}, // w
    '{SYM_DASH, SYM_DOT,  SYM_DOT,  SYM_DASH, SYM_NONE}, // x
    '{SYM_DASH, SYM_DOT,  SYM_DASH, SYM_DASH, SYM_NONE}, // y
    '{SYM_DASH, SYM_DASH, SYM_DOT,  SYM_DOT,  SYM_NONE}, // z
    '{SYM_DASH, SYM_DASH, SYM_DASH, SYM_DASH, SYM_DASH}, // 0
    '{SYM_DOT,  SYM_DASH, SYM_DASH, SYM_DASH, SYM_DASH}, // 1
    '{SYM_DOT,  SYM_DOT,  SYM_DASH, SYM_DASH, SYM_DASH}, // 2
    '{SYM_DOT,  SYM_DOT,  SYM_DOT,  SYM_DASH, SYM_DASH}, // 3
    '{SYM_DOT,  SYM_DOT,  SYM_DOT,  SYM_DOT,  SYM_DASH}, // 4
    '{SYM_DOT,  SYM_DOT,  SYM_DOT,  SYM_DOT,  SYM_DOT }, // 5
    '{SYM_DASH, SYM_DOT,  SYM_DOT,  SYM_DOT,  SYM_DOT }, // 6
    '{SYM_DASH, SYM_DASH, SYM_DOT,  SYM_DOT,  SYM_DOT }, // 7
    '{SYM_DASH, SYM_DASH, SYM_DASH, SYM_DOT,  SYM_DOT }, // 8
    '{SYM_DASH, SYM_DASH, SYM_DASH, SYM_DASH, SYM_DOT }  // 9
  };

  // Back-end sequencer states
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MARK  = 5'b00010,
    ST_GAP   = 5'b00100,
    ST_SPACE = 5'b01000,
    ST_PAUSE = 5'b10000
  } state_e;

endpackage

`default_nettype wire

[src/mck_front.sv]
// Front end: classifies each character and looks up its dot/dash pattern.
`default_nettype none

module mck_front import mck_pkg::*; #(
  parameter int unsigned SYMBOLS_PER_CHAR = 5
) (
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [CHAR_W-1:0]               char_code_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output logic                            q_space_o,
  output logic [SYMBOLS_PER_CHAR-1:0][1:0] q_pattern_o
);

  logic [ROW_W-1:0] row;
  logic             is_char;
  logic             is_space;

  always_comb begin
    row      = '0;
    is_char  = 1'b0;
    is_space = 1'b0;
    if (char_code_i >= CHAR_UPPER_A && char_code_i <= CHAR_UPPER_Z) begin
      row     = ROW_W'(char_code_i - CHAR_UPPER_A);
      is_char = 1'b1;
    end else if (char_code_i >= CHAR_LOWER_A && char_code_i <= CHAR_LOWER_Z) begin
      row     = ROW_W'(char_code_i - CHAR_LOWER_A);
      is_char = 1'b1;
    end else if (char_code_i >= CHAR_DIGIT_0 && char_code_i <= CHAR_DIGIT_9) begin
      row     = ROW_W'(char_code_i - DIGIT_ROW_OFFSET);
      is_char = 1'b1;
    end else if (char_code_i == CHAR_SPACE) begin
      is_space = 1'b1;
    end
  end

  // Slots past the ROM width stay empty
  for (genvar i = 0; i < SYMBOLS_PER_CHAR; i++) begin : g_slot
    if (i < ROM_SLOTS) begin : g_rom
      assign q_pattern_o[i] = PATTERN_ROM[row][i];
    end else begin : g_empty
      assign q_pattern_o[i] = SYM_NONE;
    end
  end

  assign in_ready_o = ~q_full_i;
  // drop characters that send nothing
  assign q_push_o   = in_valid_i & ~q_full_i & (is_char | is_space);
  assign q_space_o  = is_space;

endmodule

`default_nettype wire

[src/mck_queue.sv]
// Two-entry command queue between the front end and the sequencer.
`default_nettype none

module mck_queue #(
  parameter int unsigned WIDTH = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] entry_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;

  assign full_o     = count_q[1];
  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[src/mck_back.sv]
// Back end: walks a command's pattern and emits one timed segment per cycle while out_ready_i does not stall it.
`default_nettype none

module mck_back import mck_pkg::*; #(
  parameter int unsigned SYMBOLS_PER_CHAR = 5
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [SPEED_W-1:0]               speed_i,
  input  logic                             cmd_valid_i,
  input  logic                             cmd_space_i,
  input  logic [SYMBOLS_PER_CHAR-1:0][1:0] cmd_pattern_i,
  output logic                             cmd_pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             lamp_on_o,
  output logic [DUR_W-1:0]                 duration_us_o,
  output logic                             last_o
);

  localparam int unsigned IDX_W = (SYMBOLS_PER_CHAR > 1) ? $clog2(SYMBOLS_PER_CHAR) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SYMBOLS_PER_CHAR - 1);

  state_e                           state_q, state_d;
  logic [IDX_W-1:0]                 idx_q, idx_d;
  logic [SYMBOLS_PER_CHAR-1:0][1:0] pat_q, pat_d;
  logic                             out_valid_q;
  logic                             lamp_q;
  logic [DUR_W-1:0]                 dur_q;
  logic                             last_q;

  logic             advance;
  logic             seg_valid;
  logic             seg_lamp;
  logic             seg_last;
  dur_e             seg_dur;
  logic [IDX_W-1:0] idx_next;
  logic             load;

  assign advance  = ~out_valid_q | out_ready_i;
  assign idx_next = idx_q + IDX_W'(1);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    pat_d     = pat_q;
    seg_valid = 1'b0;
    seg_lamp  = 1'b0;
    seg_last  = 1'b0;
    seg_dur   = DUR_1U;
    load      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        load = cmd_valid_i;
      end
      ST_MARK: begin
        seg_valid = 1'b1;
        seg_lamp  = 1'b1;
        seg_dur   = (pat_q[idx_q] == SYM_DASH) ? DUR_3U : DUR_1U;
        if (advance) begin
          state_d = ST_GAP;
        end
      end
      ST_GAP: begin
        seg_valid = 1'b1;
        if (advance) begin
          // patterns are packed from slot 0, so an empty slot ends the character
          if (idx_q == LAST_IDX || pat_q[idx_next] == SYM_NONE) begin
            state_d = ST_PAUSE;
          end else begin
            idx_d   = idx_next;
            state_d = ST_MARK;
          end
        end
      end
      ST_SPACE: begin
        seg_valid = 1'b1;
        seg_dur   = DUR_8U;
        if (advance) begin
          state_d = ST_PAUSE;
        end
      end
      ST_PAUSE: begin
        seg_valid = 1'b1;
        seg_last  = 1'b1;
        seg_dur   = DUR_2U;
        if (advance) begin
          state_d = ST_IDLE;
          load    = cmd_valid_i;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (load) begin
      pat_d   = cmd_pattern_i;
      idx_d   = '0;
      state_d = cmd_space_i ? ST_SPACE : ST_MARK;
    end
  end

  assign cmd_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (advance) begin
        out_valid_q <= seg_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pat_q <= pat_d;
    if (advance) begin
      lamp_q <= seg_lamp;
      dur_q  <= DUR_TABLE[seg_dur][speed_i];
      last_q <= seg_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign lamp_on_o     = lamp_q;
  assign duration_us_o = dur_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

[src/morse_character_keyer_unit.sv]
// Morse character keyer: top level with speed register, front end, queue and sequencer.
//
// Usage:
//   in channel (in_valid_i/in_ready_o, char_code_i) takes one ASCII character per item.
//   Letters of either case and digits send their Morse pattern, a space sends a
//   word gap; any other code is accepted and sends nothing.
//   out channel (out_valid_o/out_ready_i) gives one lamp segment per item:
//   lamp_on_o, duration_us_o and last_o, the latter high on the closing pause.
//   cfg channel (cfg_valid_i/cfg_ready_o, cfg_data_i) writes the speed setting; it
//   is always ready and must only be written while no character is in flight.
// Path: when the sequencer is idle, an accepted character goes through the queue,
//   the sequencer's load and the output register before its first segment appears.
// Throughput: one segment per cycle from the sequencer while out_ready_i is high,
//   so a character gives 2*symbols+1 segments (up to 11) and a space 2.
//   A two-entry queue lets the next characters be accepted meanwhile.
// Reset: the speed setting returns to 1, queue and output register empty.
// Stall: when out_ready_i is low the output register holds its segment, the
//   sequencer waits, and the input is accepted until the queue is full.
`default_nettype none

module morse_character_keyer_unit import mck_pkg::*; #(
  parameter int unsigned SYMBOLS_PER_CHAR = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [SPEED_W-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CHAR_W-1:0]  char_code_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               lamp_on_o,
  output logic [DUR_W-1:0]   duration_us_o,
  output logic               last_o
);

  localparam int unsigned CMD_W = 1 + 2 * SYMBOLS_PER_CHAR;

  logic [SPEED_W-1:0]               speed_q;
  logic                             q_full;
  logic                             q_push;
  logic                             q_space;
  logic [SYMBOLS_PER_CHAR-1:0][1:0] q_pattern;
  logic                             q_valid;
  logic                             q_pop;
  logic [CMD_W-1:0]                 q_head;
  logic                             head_space;
  logic [SYMBOLS_PER_CHAR-1:0][1:0] head_pattern;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= SPEED_RESET;
    end else if (cfg_valid_i) begin
      speed_q <= cfg_data_i;
    end
  end

  mck_front #(
    .SYMBOLS_PER_CHAR(SYMBOLS_PER_CHAR)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .char_code_i(char_code_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_space_o  (q_space),
    .q_pattern_o(q_pattern)
  );

  mck_queue #(
    .WIDTH(CMD_W)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i({q_space, q_pattern}),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_data_o (q_head)
  );

  assign head_space   = q_head[CMD_W-1];
  assign head_pattern = q_head[CMD_W-2:0];

  mck_back #(
    .SYMBOLS_PER_CHAR(SYMBOLS_PER_CHAR)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .speed_i      (speed_q),
    .cmd_valid_i  (q_valid),
    .cmd_space_i  (head_space),
    .cmd_pattern_i(head_pattern),
    .cmd_pop_o    (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .lamp_on_o    (lamp_on_o),
    .duration_us_o(duration_us_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

[dv/keyer_segment_checker.sv]
// Checker for the Morse keyer: predicts lamp segments per character and compares them.
`timescale 1ns / 100ps

module keyer_segment_checker import mck_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [SPEED_W-1:0] cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [CHAR_W-1:0]  char_code_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               lamp_on_i,
  input  logic [DUR_W-1:0]   duration_us_i,
  input  logic               last_i,
  output int unsigned        seg_pending_o,
  output int unsigned        fail_count_o
);

  localparam int unsigned UNIT_US  = 1000000;
  localparam int unsigned MAX_SHOW = 10;

  typedef struct packed {
    logic             lamp;
    logic [DUR_W-1:0] dur;
    logic             fin;
  } segment_t;

  // Letters a..z, then digits 0..9
  string morse_tbl [36] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
    "..-", "...-", ".--", "-..-", "-.--", "--..",
    "-----", ".----", "..---", "...--", "....-",
    ".....", "-....", "--...", "---..", "----."
  };

  segment_t           expected_segs [$];
  logic [SPEED_W-1:0] speed_sel;

  initial begin
    seg_pending_o = 0;
    fail_count_o  = 0;
    speed_sel     = SPEED_RESET;
  end

  function automatic void add_segment(input logic lamp, input int unsigned units,
                                      input int unsigned speed, input logic fin);
    segment_t seg;
    seg.lamp = lamp;
    seg.dur  = DUR_W'((units * UNIT_US) / speed);
    seg.fin  = fin;
    expected_segs.push_back(seg);
  endfunction

  function automatic void predict_segments(input logic [CHAR_W-1:0] code);
    int unsigned speed;
    int          row;
    string       pat;
    sym_e        sym;
    // zero speed behaves as one
    speed = (speed_sel == 0) ? 1 : speed_sel;
    row   = -1;
    if (code >= "A" && code <= "Z") row = code - "A";
    else if (code >= "a" && code <= "z") row = code - "a";
    else if (code >= "0" && code <= "9") row = code - "0" + 26;
    if (code == " ") begin
      add_segment(1'b0, 8, speed, 1'b0);
      add_segment(1'b0, 2, speed, 1'b1);
    end else if (row >= 0) begin
      pat = morse_tbl[row];
      for (int i = 0; i < pat.len(); i++) begin
        sym = (pat[i] == "-") ? SYM_DASH : SYM_DOT;
        add_segment(1'b1, (sym == SYM_DASH) ? 3 : 1, speed, 1'b0);
        add_segment(1'b0, 1, speed, 1'b0);
      end
      add_segment(1'b0, 2, speed, 1'b1);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    segment_t want;
    if (!rst_ni) begin
      speed_sel = SPEED_RESET;
      expected_segs.delete();
      seg_pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) speed_sel = cfg_data_i;
      if (in_valid_i && in_ready_i) predict_segments(char_code_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_segs.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MAX_SHOW)
            $display("%0t: unexpected segment lamp=%0b dur=%0d last=%0b",
                     $time, lamp_on_i, duration_us_i, last_i);
        end else begin
          want = expected_segs.pop_front();
          if (want.lamp !== lamp_on_i || want.dur !== duration_us_i ||
              want.fin !== last_i) begin
            fail_count_o++;
            if (fail_count_o <= MAX_SHOW)
              $display("%0t: segment mismatch exp lamp=%0b dur=%0d last=%0b,",
                       $time, want.lamp, want.dur, want.fin,
                       " got lamp=%0b dur=%0d last=%0b",
                       lamp_on_i, duration_us_i, last_i);
          end
        end
      end
      seg_pending_o = expected_segs.size();
    end
  end

endmodule

[dv/tb_top.sv]
// Testbench top for the Morse keyer: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 100ps

module tb_top;
  import mck_pkg::*;

  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 54;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned STUCK_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CFG_SETTLE   = 8;

  localparam logic [CHAR_W-1:0] DIRECTED [20] = '{
    "A", "Z", "a", "z", "0", "9", " ", "E", "T", "5",
    8'h00, 8'hFF, "@", "[", 8'h60, "{", "/", ":", 8'h7F, 8'h80
  };
  localparam logic [SPEED_W-1:0] PHASE_SPEED [PHASES] = '{
    4'd0, 4'd15, 4'd1, 4'd7, 4'd15, 4'd0, 4'd2, 4'd9
  };
  localparam int unsigned SEND_IDLE [4] = '{0, 45, 0, 20};
  localparam int unsigned RECV_IDLE [4] = '{0, 0, 45, 20};

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic [SPEED_W-1:0] cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic [CHAR_W-1:0]  char_code_i = '0;
  logic               out_ready_i = 1'b0;
  logic               cfg_ready_o;
  logic               in_ready_o;
  logic               out_valid_o;
  logic               lamp_on_o;
  logic [DUR_W-1:0]   duration_us_o;
  logic               last_o;

  int unsigned seg_pending;
  int unsigned fail_count;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req      = 0;
  int unsigned hold_left     = 0;
  int unsigned stuck_cycles  = 0;

  always #5 clk_i = ~clk_i;

  morse_character_keyer_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .char_code_i   (char_code_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .lamp_on_o     (lamp_on_o),
    .duration_us_o (duration_us_o),
    .last_o        (last_o)
  );

  keyer_segment_checker u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .char_code_i   (char_code_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .lamp_on_i     (lamp_on_o),
    .duration_us_i (duration_us_o),
    .last_i        (last_o),
    .seg_pending_o (seg_pending),
    .fail_count_o  (fail_count)
  );

  // Receiver: random stalls, or a long counted hold-off on request
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_ready_i = 1'b0;
      hold_left--;
    end else begin
      out_ready_i = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Mostly letters, digits and spaces, with some arbitrary codes
  function automatic logic [CHAR_W-1:0] pick_char();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 30) return CHAR_W'("A" + $urandom_range(25));
    if (sel < 60) return CHAR_W'("a" + $urandom_range(25));
    if (sel < 80) return CHAR_W'("0" + $urandom_range(9));
    if (sel < 86) return " ";
    return CHAR_W'($urandom_range(255));
  endfunction

  task automatic send_char(input logic [CHAR_W-1:0] code);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    char_code_i = code;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Drain all segments, then let silent characters clear before writing
  task automatic drain_out();
    in_valid_i = 1'b0;
    wait (seg_pending == 0);
    @(negedge clk_i);
    repeat (CFG_SETTLE) @(negedge clk_i);
  endtask

  task automatic write_speed(input logic [SPEED_W-1:0] speed);
    drain_out();
    cfg_valid_i = 1'b1;
    cfg_data_i  = speed;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset speed first, then the edge characters
    foreach (DIRECTED[i]) send_char(DIRECTED[i]);

    for (int p = 0; p < PHASES; p++) begin
      write_speed((p == PHASES - 1) ? SPEED_W'($urandom_range(15)) : PHASE_SPEED[p]);
      send_idle_pct = SEND_IDLE[p % 4];
      recv_idle_pct = RECV_IDLE[p % 4];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 4 && n == 5) hold_req = 1;
        // hold the sender until every segment is out
        if (p == 6 && n == PHASE_ITEMS / 2) drain_out();
        send_char(pick_char());
      end
    end

    in_valid_i = 1'b0;
    wait (seg_pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
